FILE: rtl/ptrot_pkg.sv
// ----------------------------------------------------------------------------
// ptrot_pkg: shared types, constants and sine table
// Widths of the rotation datapath, config register codes and the Q12 sine
// table built at elaboration from the integer sine polynomial.
// ----------------------------------------------------------------------------
package ptrot_pkg;

  // field and datapath widths
  localparam int PointW = 16;
  localparam int AngleW = 8;
  localparam int CoordW = 24;
  localparam int CoefW  = 16;
  localparam int ProdW  = CoordW + CoefW;
  localparam int FracW  = 12;
  localparam int CfgIdxW = 2;

  // projection constants
  localparam int DepthBias = 512;
  localparam int DepthMin  = 64;
  localparam int Focal     = 160;
  localparam int Centre    = 80;

  // sine polynomial constants
  localparam longint unsigned PolyA = 64'd3370945099;
  localparam longint unsigned PolyB = 64'd2746362156;
  localparam longint unsigned PolyC = 64'd292421;
  localparam longint unsigned Mask32 = 64'hFFFF_FFFF;

  // quarter turn in table steps, for the cosine
  localparam logic [AngleW-1:0] QuarterTurn = AngleW'(64);

  typedef enum logic [CfgIdxW-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } cfg_reg_e;

  typedef logic signed [CoefW-1:0] sin_tab_t [256];

  // sine and cosine of the three axes
  typedef struct packed {
    logic signed [CoefW-1:0] sin_x;
    logic signed [CoefW-1:0] cos_x;
    logic signed [CoefW-1:0] sin_y;
    logic signed [CoefW-1:0] cos_y;
    logic signed [CoefW-1:0] sin_z;
    logic signed [CoefW-1:0] cos_z;
  } trig_t;

  // q12 sine of a 15-bit turn angle
  function automatic logic [CoefW-1:0] poly_sin(longint unsigned ang);
    longint unsigned t;
    longint unsigned k;
    longint unsigned y;
    longint unsigned r;
    logic neg;
    t = (ang << 1) & 64'hFFFF;
    neg = t[15];
    if ((t & 64'h4000) != 0) t = (64'h8000 - t) & 64'hFFFF;
    k = (t & 64'h7FFF) >> 1;
    y = ((PolyC * k) & Mask32) >> 13;
    y = (PolyB - (((k * y) & Mask32) >> 3)) & Mask32;
    y = (k * (y >> 13)) & Mask32;
    y = (k * (y >> 13)) & Mask32;
    y = (PolyA - (y >> 1)) & Mask32;
    y = (k * (y >> 13)) & Mask32;
    y = (y + 64'd262144) >> 19;
    r = neg ? ((64'd0 - y) & Mask32) : y;
    return r[CoefW-1:0];
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    for (int a = 0; a < 256; a++) begin
      tab[a] = poly_sin(longint'(a) * 128);
    end
    return tab;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

endpackage

FILE: rtl/point_rotate_project.sv
// ----------------------------------------------------------------------------
// point_rotate_project: 3d point rotation and perspective projection
// Stages from input transfer to result: three rotations of two stages each,
// one projection setup stage, twelve divider stages of two quotient bits
// each and one output stage. One point is taken every cycle unless stalled.
// The whole pipeline holds while a result waits on m_axis_tready.
// Reset clears all valid bits and sets the three angles to zero.
// ----------------------------------------------------------------------------
module point_rotate_project (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptrot_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [ptrot_pkg::AngleW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // point_x, point_y, point_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // screen_x, screen_y, rotated_depth
  output logic                          m_axis_tuser   // near_clamped
);

  localparam int CW = ptrot_pkg::CoordW;
  localparam int PW = ptrot_pkg::PointW;

  ptrot_pkg::trig_t trig;
  logic             en;

  logic signed [CW-1:0] x0, y0, z0;
  logic                 v1, v2, v3;
  logic signed [CW-1:0] z1, x1, y1c;
  logic signed [CW-1:0] y2, z2, x2c;
  logic signed [CW-1:0] x3, y3, z3c;

  logic          proj_vld;
  logic [PW-1:0] scr_x, scr_y, dep;
  logic          near;

  // whole pipeline advances unless a result is stuck at the output
  assign en            = !proj_vld || m_axis_tready;
  assign s_axis_tready = en;

  ptrot_trig u_trig (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .trig_o     (trig)
  );

  // unpack and sign extend the point
  always_comb begin
    x0 = CW'($signed(s_axis_tdata[15:0]));
    y0 = CW'($signed(s_axis_tdata[31:16]));
    z0 = CW'($signed(s_axis_tdata[47:32]));
  end

  // rotation about y
  ptrot_rotate u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .p_i     (z0),
    .q_i     (x0),
    .carry_i (y0),
    .sin_i   (trig.sin_y),
    .cos_i   (trig.cos_y),
    .valid_o (v1),
    .p_o     (z1),
    .q_o     (x1),
    .carry_o (y1c)
  );

  // rotation about x
  ptrot_rotate u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .p_i     (y1c),
    .q_i     (z1),
    .carry_i (x1),
    .sin_i   (trig.sin_x),
    .cos_i   (trig.cos_x),
    .valid_o (v2),
    .p_o     (y2),
    .q_o     (z2),
    .carry_o (x2c)
  );

  // rotation about z
  ptrot_rotate u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .p_i     (x2c),
    .q_i     (y2),
    .carry_i (z2),
    .sin_i   (trig.sin_z),
    .cos_i   (trig.cos_z),
    .valid_o (v3),
    .p_o     (x3),
    .q_o     (y3),
    .carry_o (z3c)
  );

  ptrot_proj u_proj (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3),
    .rx_i       (x3[PW-1:0]),
    .ry_i       (y3[PW-1:0]),
    .rz_i       (z3c[PW-1:0]),
    .valid_o    (proj_vld),
    .screen_x_o (scr_x),
    .screen_y_o (scr_y),
    .depth_o    (dep),
    .near_o     (near)
  );

  assign m_axis_tvalid = proj_vld;
  assign m_axis_tdata  = {dep, scr_y, scr_x};
  assign m_axis_tuser  = near;

endmodule

FILE: rtl/ptrot_trig.sv
// ----------------------------------------------------------------------------
// ptrot_trig: angle registers and sine/cosine lookup
// Each angle write stores the sine and cosine of that angle from the table.
// ----------------------------------------------------------------------------
module ptrot_trig (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ptrot_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [ptrot_pkg::AngleW-1:0]  cfg_data_i,
  output ptrot_pkg::trig_t              trig_o
);

  ptrot_pkg::trig_t trig_q;
  logic signed [ptrot_pkg::CoefW-1:0] sin_w;
  logic signed [ptrot_pkg::CoefW-1:0] cos_w;

  // table lookup of the written angle
  always_comb begin
    sin_w = ptrot_pkg::SinTab[cfg_data_i];
    cos_w = ptrot_pkg::SinTab[cfg_data_i + ptrot_pkg::QuarterTurn];
  end

  // coefficient registers, reset to angle zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q.sin_x <= ptrot_pkg::SinTab[0];
      trig_q.cos_x <= ptrot_pkg::SinTab[ptrot_pkg::QuarterTurn];
      trig_q.sin_y <= ptrot_pkg::SinTab[0];
      trig_q.cos_y <= ptrot_pkg::SinTab[ptrot_pkg::QuarterTurn];
      trig_q.sin_z <= ptrot_pkg::SinTab[0];
      trig_q.cos_z <= ptrot_pkg::SinTab[ptrot_pkg::QuarterTurn];
    end else if (cfg_we_i) begin
      case (ptrot_pkg::cfg_reg_e'(cfg_addr_i))
        ptrot_pkg::REG_ANGLE_X: begin
          trig_q.sin_x <= sin_w;
          trig_q.cos_x <= cos_w;
        end
        ptrot_pkg::REG_ANGLE_Y: begin
          trig_q.sin_y <= sin_w;
          trig_q.cos_y <= cos_w;
        end
        ptrot_pkg::REG_ANGLE_Z: begin
          trig_q.sin_z <= sin_w;
          trig_q.cos_z <= cos_w;
        end
        default: ;
      endcase
    end
  end

  assign trig_o = trig_q;

endmodule

FILE: rtl/ptrot_rotate.sv
// ----------------------------------------------------------------------------
// ptrot_rotate: one plane rotation in two register stages
// p' = (p*c - q*s) >>> 12, q' = (p*s + q*c) >>> 12; the third coordinate
// travels alongside.
// ----------------------------------------------------------------------------
module ptrot_rotate (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [ptrot_pkg::CoordW-1:0] p_i,
  input  logic signed [ptrot_pkg::CoordW-1:0] q_i,
  input  logic signed [ptrot_pkg::CoordW-1:0] carry_i,
  input  logic signed [ptrot_pkg::CoefW-1:0]  sin_i,
  input  logic signed [ptrot_pkg::CoefW-1:0]  cos_i,
  output logic                                valid_o,
  output logic signed [ptrot_pkg::CoordW-1:0] p_o,
  output logic signed [ptrot_pkg::CoordW-1:0] q_o,
  output logic signed [ptrot_pkg::CoordW-1:0] carry_o
);

  localparam int PW = ptrot_pkg::ProdW;
  localparam int SW = PW + 1;
  localparam int FW = ptrot_pkg::FracW;
  localparam int CW = ptrot_pkg::CoordW;

  logic                 mul_vld_q;
  logic signed [PW-1:0] pc_q, qs_q, ps_q, qc_q;
  logic signed [CW-1:0] mul_carry_q;
  logic signed [SW-1:0] sum_p_d, sum_q_d;
  logic                 sum_vld_q;
  logic signed [CW-1:0] p_q, q_q, carry_q;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (en_i) begin
      mul_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q        <= PW'(p_i * cos_i);
      qs_q        <= PW'(q_i * sin_i);
      ps_q        <= PW'(p_i * sin_i);
      qc_q        <= PW'(q_i * cos_i);
      mul_carry_q <= carry_i;
    end
  end

  // sum and floor shift stage
  always_comb begin
    sum_p_d = SW'(pc_q) - SW'(qs_q);
    sum_q_d = SW'(ps_q) + SW'(qc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else if (en_i) begin
      sum_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= sum_p_d[FW+CW-1:FW];
      q_q     <= sum_q_d[FW+CW-1:FW];
      carry_q <= mul_carry_q;
    end
  end

  assign valid_o = sum_vld_q;
  assign p_o     = p_q;
  assign q_o     = q_q;
  assign carry_o = carry_q;

endmodule

FILE: rtl/ptrot_proj.sv
// ----------------------------------------------------------------------------
// ptrot_proj: perspective projection
// Depth bias and near clamp, then two pipelined restoring dividers (two
// quotient bits per stage) for x*160/depth and y*160/depth, then centering.
// ----------------------------------------------------------------------------
module ptrot_proj (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [ptrot_pkg::PointW-1:0] rx_i,
  input  logic signed [ptrot_pkg::PointW-1:0] ry_i,
  input  logic signed [ptrot_pkg::PointW-1:0] rz_i,
  output logic                                valid_o,
  output logic [ptrot_pkg::PointW-1:0]        screen_x_o,
  output logic [ptrot_pkg::PointW-1:0]        screen_y_o,
  output logic [ptrot_pkg::PointW-1:0]        depth_o,
  output logic                                near_o
);

  localparam int PtW = ptrot_pkg::PointW;
  localparam int NP  = 24;
  localparam int DW  = 16;
  localparam int BPS = 2;
  localparam int STG = NP / BPS;
  localparam int VW  = PtW + 1;

  logic signed [NP-1:0] num_x_w, num_y_w;
  logic signed [VW-1:0] view_w;
  logic [DW-1:0]        dvs_w;
  logic                 near_w;

  logic            vld_q  [STG+1];
  logic [NP-1:0]   num_q  [STG+1][2];
  logic [NP-1:0]   quo_q  [STG+1][2];
  logic [DW-1:0]   rem_q  [STG+1][2];
  logic            neg_q  [STG+1][2];
  logic [DW-1:0]   dvs_q  [STG+1];
  logic [PtW-1:0]  dep_q  [STG+1];
  logic            near_q [STG+1];

  logic            out_vld_q;
  logic [PtW-1:0]  scr_d  [2];
  logic [PtW-1:0]  scr_q  [2];
  logic [PtW-1:0]  out_dep_q;
  logic            out_near_q;

  // scale by focal length, bias depth and clamp at the near plane
  always_comb begin
    num_x_w = NP'(rx_i) * NP'(ptrot_pkg::Focal);
    num_y_w = NP'(ry_i) * NP'(ptrot_pkg::Focal);
    view_w  = VW'(rz_i) + VW'(ptrot_pkg::DepthBias);
    near_w  = view_w < VW'(ptrot_pkg::DepthMin);
    dvs_w   = near_w ? DW'(ptrot_pkg::DepthMin) : view_w[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0][0] <= num_x_w[NP-1] ? NP'(-num_x_w) : num_x_w;
      num_q[0][1] <= num_y_w[NP-1] ? NP'(-num_y_w) : num_y_w;
      neg_q[0][0] <= num_x_w[NP-1];
      neg_q[0][1] <= num_y_w[NP-1];
      quo_q[0][0] <= '0;
      quo_q[0][1] <= '0;
      rem_q[0][0] <= '0;
      rem_q[0][1] <= '0;
      dvs_q[0]    <= dvs_w;
      dep_q[0]    <= rz_i;
      near_q[0]   <= near_w;
    end
  end

  // divider stages
  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [DW-1:0] rem_d [2];
    logic [NP-1:0] num_d [2];
    logic [NP-1:0] quo_d [2];

    // two restoring steps per lane
    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [NP-1:0] n;
      logic [NP-1:0] q;
      for (int l = 0; l < 2; l++) begin
        r = rem_q[s][l];
        n = num_q[s][l];
        q = quo_q[s][l];
        for (int b = 0; b < BPS; b++) begin
          t = {r, n[NP-1]};
          n = {n[NP-2:0], 1'b0};
          if (t >= {1'b0, dvs_q[s]}) begin
            r = DW'(t - {1'b0, dvs_q[s]});
            q = {q[NP-2:0], 1'b1};
          end else begin
            r = t[DW-1:0];
            q = {q[NP-2:0], 1'b0};
          end
        end
        rem_d[l] = r;
        num_d[l] = n;
        quo_d[l] = q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          rem_q[s+1][l] <= rem_d[l];
          num_q[s+1][l] <= num_d[l];
          quo_q[s+1][l] <= quo_d[l];
          neg_q[s+1][l] <= neg_q[s][l];
        end
        dvs_q[s+1]  <= dvs_q[s];
        dep_q[s+1]  <= dep_q[s];
        near_q[s+1] <= near_q[s];
      end
    end
  end

  // restore sign, wrap to 16 bits and add the screen centre
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      scr_d[l] = (neg_q[STG][l] ? PtW'(-quo_q[STG][l][PtW-1:0])
                                : quo_q[STG][l][PtW-1:0])
                 + PtW'(ptrot_pkg::Centre);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scr_q[0]   <= scr_d[0];
      scr_q[1]   <= scr_d[1];
      out_dep_q  <= dep_q[STG];
      out_near_q <= near_q[STG];
    end
  end

  assign valid_o    = out_vld_q;
  assign screen_x_o = scr_q[0];
  assign screen_y_o = scr_q[1];
  assign depth_o    = out_dep_q;
  assign near_o     = out_near_q;

endmodule
